### rtl/vwdf_pkg.sv
// ----------------------------------------------------------------------------
// Valley window day finder package
// Shared defaults and register map for the valley window day finder.
// ----------------------------------------------------------------------------
package vwdf_pkg;

  // Default sizing of the block.
  localparam int unsigned DEF_MAX_WINDOW  = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 32;
  localparam longint unsigned DEF_MAX_DAYS = 64'd65536;

  // Fixed field widths of the stream and register interfaces.
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned WINDOW_W   = 11;
  localparam int unsigned DAY_IDX_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_UNMAPPED      = 1'b1
  } reg_index_t;

endpackage

### rtl/valley_window_day_finder.sv
// ----------------------------------------------------------------------------
// Valley window day finder
// Streams samples and flags days framed by a non-rising and a non-falling run.
// ----------------------------------------------------------------------------
// The block takes one sample word per cycle and returns one result word per
// sample, so it sustains one word per clock while out_tready stays high. When
// a sample is accepted, stage one captures its state and the history read
// starts; the output register is loaded from stage one once it is free. That
// rate is set by the run counters, which are updated from the previous
// sample, and by the history RAM, which takes one flag write and
// one flag read per sample.
// For each sample k the result judges day k - window_length: good_day is set
// when the window_length samples before that day never rose and the
// window_length samples after it never fell. Until window_length samples have
// arrived, or when window_length exceeds MAX_WINDOW, good_day and day_index
// read as zero. A word with tlast set ends a sequence; its result carries
// tlast, and the block then starts the next sequence from a clean state. The
// history RAM is never cleared: a flag is only read once it has been written
// within the current sequence, so no clearing pass follows reset. The
// window_length register must only be written while the block is idle.
// ----------------------------------------------------------------------------
module valley_window_day_finder
  import vwdf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter longint unsigned MAX_DAYS = DEF_MAX_DAYS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [31:0] sample_value
  input  logic                  in_tlast,   // last_sample
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] good_day, [16:1] day_index, zero above
  output logic                  out_tlast,  // sequence_end
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Sample bits that take part in the compares.
  localparam int unsigned SB     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  // Run counters saturate at MAX_WINDOW.
  localparam int unsigned RUN_W  = $clog2(MAX_WINDOW + 1);
  // The history holds one flag per sample for the last MAX_WINDOW+1 samples.
  localparam int unsigned DEPTH  = MAX_WINDOW + 1;
  localparam int unsigned AW     = $clog2(DEPTH);
  // Day counter saturates at MAX_DAYS-1.
  localparam int unsigned CNT_W  = (MAX_DAYS > 64'd2) ? $clog2(MAX_DAYS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DAYS - 64'd1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_WINDOW);
  localparam logic [AW-1:0]    PTR_MAX = AW'(MAX_WINDOW);

  // --------------------------------------------------------------------------
  // Configuration register. pready is always high, so a write lands at the
  // access phase of the transfer.
  // --------------------------------------------------------------------------
  logic [WINDOW_W-1:0] window_r;
  reg_index_t          cfg_index;
  logic                cfg_wr;

  assign cfg_index  = reg_index_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (cfg_wr && (cfg_index == REG_WINDOW_LENGTH)) begin
      window_r <= cfg_pwdata[WINDOW_W-1:0];
    end
  end

  always_comb begin
    case (cfg_index)
      REG_WINDOW_LENGTH: cfg_prdata = CFG_DATA_W'(window_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake. Stage one waits for the history read; the output
  // register holds a finished result so that stage one can keep moving.
  // --------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic accept;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Run tracking on the accepted sample.
  // --------------------------------------------------------------------------
  logic [SB-1:0]    prev_r;
  logic             have_prev_r;
  logic [RUN_W-1:0] fall_r, fall_nxt;
  logic [RUN_W-1:0] rise_r, rise_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [SB-1:0]    x;
  logic             w_ok;
  logic             fall_flag;
  logic             rise_ok;
  logic             eval;
  logic [31:0]      diff;
  logic [AW-1:0]    w_a;
  logic [AW:0]      raddr_wide;
  logic [AW-1:0]    raddr;

  assign x    = in_tdata[SB-1:0];
  assign w_ok = 32'(window_r) <= 32'(MAX_WINDOW);
  assign w_a  = AW'(window_r);

  always_comb begin
    if (have_prev_r) begin
      fall_nxt = (prev_r >= x) ? ((fall_r == RUN_MAX) ? fall_r : fall_r + 1'b1) : '0;
      rise_nxt = (prev_r <= x) ? ((rise_r == RUN_MAX) ? rise_r : rise_r + 1'b1) : '0;
    end else begin
      fall_nxt = '0;
      rise_nxt = '0;
    end
  end

  assign fall_flag = w_ok && (32'(fall_nxt) >= 32'(window_r));
  assign rise_ok   = 32'(rise_nxt) >= 32'(window_r);
  // A day can be judged once window_length samples of this sequence are in.
  assign eval      = w_ok && (32'(cnt_r) >= 32'(window_r));
  assign diff      = 32'(cnt_r) - 32'(window_r);

  assign cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign ptr_nxt = (ptr_r == PTR_MAX) ? '0 : ptr_r + 1'b1;

  // The flag of sample k - window_length sits window_length slots behind the
  // write pointer, modulo the history depth.
  always_comb begin
    if (ptr_r >= w_a) begin
      raddr_wide = {1'b0, ptr_r} - {1'b0, w_a};
    end else begin
      raddr_wide = {1'b0, ptr_r} + (AW + 1)'(DEPTH) - {1'b0, w_a};
    end
  end
  assign raddr = raddr_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      fall_r      <= '0;
      rise_r      <= '0;
      cnt_r       <= '0;
      ptr_r       <= '0;
    end else if (accept) begin
      ptr_r <= ptr_nxt;
      if (in_tlast) begin
        prev_r      <= '0;
        have_prev_r <= 1'b0;
        fall_r      <= '0;
        rise_r      <= '0;
        cnt_r       <= '0;
      end else begin
        prev_r      <= x;
        have_prev_r <= 1'b1;
        fall_r      <= fall_nxt;
        rise_r      <= rise_nxt;
        cnt_r       <= cnt_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Fall history. With a zero window the flag just computed is the one that
  // is needed, so it is forwarded around the RAM.
  // --------------------------------------------------------------------------
  logic hist_rdata;

  vwdf_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (ptr_r),
    .wdata (fall_flag),
    .re    (accept),
    .raddr (raddr),
    .rdata (hist_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage one: wait for the history flag.
  // --------------------------------------------------------------------------
  logic                 s1_eval_r;
  logic                 s1_fwd_r;
  logic                 s1_fwd_flag_r;
  logic                 s1_rise_ok_r;
  logic [DAY_IDX_W-1:0] s1_idx_r;
  logic                 s1_last_r;
  logic                 s1_good;

  assign s1_valid_nxt = accept || (s1_valid_r && !s1_adv);
  assign s1_good      = s1_eval_r && s1_rise_ok_r && (s1_fwd_r ? s1_fwd_flag_r : hist_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_eval_r     <= eval;
      s1_fwd_r      <= (window_r == '0);
      s1_fwd_flag_r <= fall_flag;
      s1_rise_ok_r  <= rise_ok;
      s1_idx_r      <= eval ? DAY_IDX_W'(diff) : '0;
      s1_last_r     <= in_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic                 out_good_r;
  logic [DAY_IDX_W-1:0] out_idx_r;
  logic                 out_last_r;

  assign out_valid_nxt = s1_adv || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_good_r <= s1_good;
      out_idx_r  <= s1_idx_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - DAY_IDX_W - 1)'(0), out_idx_r, out_good_r};
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A word waiting on its history flag must not be overwritten by a new one.
  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !accept)
    else $error("stage one overwritten while stalled");

  // A stalled stage one keeps its word.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("stage one word lost while stalled");

  // The end of a sequence leaves a clean run state behind.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (cnt_r == '0) && !have_prev_r && (fall_r == '0) && (rise_r == '0))
    else $error("state not cleared after last sample");

  // Run counters never pass their saturation value.
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fall_r <= RUN_MAX) && (rise_r <= RUN_MAX))
    else $error("run counter beyond saturation");

endmodule

### rtl/vwdf_ram.sv
// ----------------------------------------------------------------------------
// Valley window day finder RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vwdf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
